// ----- hw/rtl/trdf_pkg.sv -----
package trdf_pkg;

  // Drive modes, in the encoding reported as mode_now.
  typedef enum logic [2:0] {
    MODE_STOP = 3'd0,
    MODE_FWD  = 3'd1,
    MODE_REV  = 3'd2,
    MODE_HFWD = 3'd3,
    MODE_HREV = 3'd4
  } mode_e;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_ACCEL_RATE    = 3'd0,
    REG_BRAKE_RATE    = 3'd1,
    REG_COAST_RATE    = 3'd2,
    REG_MAX_SPEED     = 3'd3,
    REG_HOLD_FWD_TIME = 3'd4,
    REG_HOLD_REV_TIME = 3'd5,
    REG_SPIN_RATE     = 3'd6,
    REG_DEAD_ZONE_SQ  = 3'd7
  } reg_e;

  localparam int unsigned HOLD_W  = 25;
  localparam int unsigned DRIVE_W = 24;
  localparam int unsigned SPIN_W  = 17;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned MAXS_W  = 23;
  localparam int unsigned HTIME_W = 24;

  // Per-item flags handed from the front end to the back end.
  typedef struct packed {
    logic pedal_accel;
    logic pedal_brake;
    logic boost_left;
    logic boost_right;
    logic spin_sel;     // stick points sideways past the dead zone
  } flags_t;

  // Result item as packed on the output stream, lowest field last.
  typedef struct packed {
    logic                   pad;
    logic [2:0]             mode_now;
    logic                   boost_right_out;
    logic                   boost_left_out;
    logic [SPIN_W-1:0]      spin_amount;
    logic [DRIVE_W-1:0]     drive_speed;
    logic                   send_valid;
  } out_t;

endpackage

// ----- hw/rtl/trdf_front.sv -----
module trdf_front #(
  parameter int unsigned TIME_FRAC_BITS = 16,
  localparam int unsigned STEP_W = 32 - TIME_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // incoming item
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               pedal_accel_i,
  input  logic                               pedal_brake_i,
  input  logic                               boost_left_i,
  input  logic                               boost_right_i,
  input  logic signed [trdf_pkg::AXIS_W-1:0] stick_lateral_i,
  input  logic signed [trdf_pkg::AXIS_W-1:0] stick_other_i,
  input  logic [trdf_pkg::DT_W-1:0]          time_step_i,
  // configuration
  input  logic [trdf_pkg::RATE_W-1:0]        accel_rate_i,
  input  logic [trdf_pkg::RATE_W-1:0]        brake_rate_i,
  input  logic [trdf_pkg::RATE_W-1:0]        coast_rate_i,
  input  logic [trdf_pkg::RATE_W-1:0]        spin_rate_i,
  input  logic [31:0]                        dead_zone_sq_i,
  // classified item toward the queue
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output trdf_pkg::flags_t                   flags_o,
  output logic [STEP_W-1:0]                  step_a_o,
  output logic [STEP_W-1:0]                  step_b_o,
  output logic [STEP_W-1:0]                  step_c_o,
  output logic [trdf_pkg::SPIN_W-1:0]        spin_o,
  output logic [trdf_pkg::DT_W-1:0]          dt_o
);

  localparam int unsigned SW = (STEP_W + 1 > trdf_pkg::SPIN_W) ? STEP_W + 1
                                                               : trdf_pkg::SPIN_W;

  logic        vld_q;
  logic        acc_q, brk_q, bl_q, br_q;
  logic        x_pos_q, x_neg_q;
  logic [31:0] pa_q, pb_q, pc_q, ps_q;
  logic [30:0] xx_q, yy_q;
  logic [trdf_pkg::DT_W-1:0] dt_q;

  logic signed [31:0] xsq, ysq;
  logic               take;

  assign take       = in_valid_i && in_ready_o;
  assign in_ready_o = !vld_q || out_ready_i;
  assign xsq        = stick_lateral_i * stick_lateral_i;
  assign ysq        = stick_other_i * stick_other_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // Products are registered here; the back end only adds and compares.
  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q   <= pedal_accel_i;
      brk_q   <= pedal_brake_i;
      bl_q    <= boost_left_i;
      br_q    <= boost_right_i;
      x_pos_q <= !stick_lateral_i[trdf_pkg::AXIS_W-1] && (stick_lateral_i != '0);
      x_neg_q <= stick_lateral_i[trdf_pkg::AXIS_W-1];
      pa_q    <= accel_rate_i * time_step_i;
      pb_q    <= brake_rate_i * time_step_i;
      pc_q    <= coast_rate_i * time_step_i;
      ps_q    <= spin_rate_i * time_step_i;
      xx_q    <= xsq[30:0];
      yy_q    <= ysq[30:0];
      dt_q    <= time_step_i;
    end
  end

  logic [31:0]          len2;
  logic [32:0]          x3;
  logic                 live, side, left, right;
  logic [STEP_W-1:0]    step_s;
  logic signed [SW-1:0] ss_ext, spin_full;

  always_comb begin
    len2   = {1'b0, xx_q} + {1'b0, yy_q};
    x3     = {1'b0, xx_q, 1'b0} + {2'b00, xx_q};
    live   = len2 > dead_zone_sq_i;
    side   = live && (x3 > {2'b00, yy_q});
    // A positive lateral axis means a left turn, which spins negative.
    left   = side && x_pos_q;
    right  = side && x_neg_q;
    step_s = ps_q[31:TIME_FRAC_BITS];
    ss_ext = SW'(step_s);
    if (left) begin
      spin_full = -ss_ext;
    end else if (right) begin
      spin_full = ss_ext;
    end else begin
      spin_full = '0;
    end
  end

  assign out_valid_o          = vld_q;
  assign flags_o.pedal_accel  = acc_q;
  assign flags_o.pedal_brake  = brk_q;
  assign flags_o.boost_left   = bl_q;
  assign flags_o.boost_right  = br_q;
  assign flags_o.spin_sel     = left || right;
  assign step_a_o             = pa_q[31:TIME_FRAC_BITS];
  assign step_b_o             = pb_q[31:TIME_FRAC_BITS];
  assign step_c_o             = pc_q[31:TIME_FRAC_BITS];
  assign spin_o               = spin_full[trdf_pkg::SPIN_W-1:0];
  assign dt_o                 = dt_q;

endmodule

// ----- hw/rtl/trdf_fifo.sv -----
module trdf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/trdf_back.sv -----
module trdf_back #(
  parameter int unsigned TIME_FRAC_BITS = 16,
  localparam int unsigned STEP_W = 32 - TIME_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // classified item from the queue
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  trdf_pkg::flags_t                    flags_i,
  input  logic [STEP_W-1:0]                   step_a_i,
  input  logic [STEP_W-1:0]                   step_b_i,
  input  logic [STEP_W-1:0]                   step_c_i,
  input  logic [trdf_pkg::SPIN_W-1:0]         spin_i,
  input  logic [trdf_pkg::DT_W-1:0]           dt_i,
  // configuration
  input  logic [trdf_pkg::MAXS_W-1:0]         max_speed_i,
  input  logic [trdf_pkg::HTIME_W-1:0]        hold_fwd_time_i,
  input  logic [trdf_pkg::HTIME_W-1:0]        hold_rev_time_i,
  // result item
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output trdf_pkg::out_t                      out_data_o
);

  // The speed must hold an unclamped entry step of either sign.
  localparam int unsigned SPD_W = (STEP_W + 1 > trdf_pkg::DRIVE_W) ? STEP_W + 1
                                                                   : trdf_pkg::DRIVE_W;
  localparam int unsigned V_W   = SPD_W + 2;

  trdf_pkg::mode_e                    mode_q, mode_d;
  logic signed [SPD_W-1:0]            speed_q, speed_d;
  logic signed [trdf_pkg::HOLD_W-1:0] hold_q, hold_d, hold_nx;
  logic                               ovld_q;
  trdf_pkg::out_t                     odata_q, odata_d;
  logic                               pop;

  logic signed [V_W-1:0] sa_v, sb_v, sc_v, spd_v, max_v, sum_v, clip_v;

  assign in_ready_o  = !ovld_q || out_ready_i;
  assign pop         = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;

  always_comb begin
    sa_v    = V_W'(step_a_i);
    sb_v    = V_W'(step_b_i);
    sc_v    = V_W'(step_c_i);
    spd_v   = V_W'(speed_q);
    max_v   = V_W'(max_speed_i);
    hold_nx = hold_q - $signed({{(trdf_pkg::HOLD_W - trdf_pkg::DT_W){1'b0}}, dt_i});
    sum_v   = spd_v;
    clip_v  = spd_v;
    mode_d  = mode_q;
    speed_d = speed_q;
    hold_d  = hold_q;

    unique case (mode_q)
      trdf_pkg::MODE_FWD: begin
        if (flags_i.pedal_brake) begin
          sum_v = spd_v - sb_v;
        end else if (flags_i.pedal_accel) begin
          sum_v = spd_v + sa_v;
        end else begin
          sum_v = spd_v - sc_v;
        end
        if (sum_v < 0) begin
          clip_v = '0;
        end else if (sum_v > max_v) begin
          clip_v = max_v;
        end else begin
          clip_v = sum_v;
        end
        speed_d = clip_v[SPD_W-1:0];
        if (clip_v == '0) begin
          hold_d = trdf_pkg::HOLD_W'(hold_fwd_time_i);
          mode_d = trdf_pkg::MODE_HFWD;
        end
      end
      trdf_pkg::MODE_REV: begin
        if (flags_i.pedal_accel) begin
          sum_v = spd_v + sb_v;
        end else if (flags_i.pedal_brake) begin
          sum_v = spd_v - sa_v;
        end else begin
          sum_v = spd_v + sc_v;
        end
        if (sum_v > 0) begin
          clip_v = '0;
        end else if (sum_v < -max_v) begin
          clip_v = -max_v;
        end else begin
          clip_v = sum_v;
        end
        speed_d = clip_v[SPD_W-1:0];
        if (clip_v == '0) begin
          hold_d = trdf_pkg::HOLD_W'(hold_rev_time_i);
          mode_d = trdf_pkg::MODE_HREV;
        end
      end
      trdf_pkg::MODE_HFWD: begin
        if (flags_i.pedal_accel) begin
          speed_d = SPD_W'(step_a_i);
          mode_d  = trdf_pkg::MODE_FWD;
        end else begin
          hold_d = hold_nx;
          if (hold_nx[trdf_pkg::HOLD_W-1] || hold_nx == '0) begin
            mode_d = trdf_pkg::MODE_STOP;
          end
        end
      end
      trdf_pkg::MODE_HREV: begin
        if (flags_i.pedal_brake) begin
          speed_d = '0 - SPD_W'(step_a_i);
          mode_d  = trdf_pkg::MODE_REV;
        end else begin
          hold_d = hold_nx;
          if (hold_nx[trdf_pkg::HOLD_W-1] || hold_nx == '0) begin
            mode_d = trdf_pkg::MODE_STOP;
          end
        end
      end
      default: begin
        mode_d = trdf_pkg::MODE_STOP;
        if (flags_i.pedal_accel) begin
          speed_d = SPD_W'(step_a_i);
          mode_d  = trdf_pkg::MODE_FWD;
        end else if (flags_i.pedal_brake) begin
          speed_d = '0 - SPD_W'(step_a_i);
          mode_d  = trdf_pkg::MODE_REV;
        end
      end
    endcase

    odata_d          = '0;
    odata_d.mode_now = mode_d;
    if (speed_d != '0) begin
      odata_d.send_valid      = 1'b1;
      odata_d.drive_speed     = speed_d[trdf_pkg::DRIVE_W-1:0];
      odata_d.boost_left_out  = flags_i.boost_left;
      odata_d.boost_right_out = flags_i.boost_right;
    end else if (mode_d == trdf_pkg::MODE_STOP) begin
      // Standing still: a spin command, or an idle command with nitros off.
      odata_d.send_valid      = 1'b1;
      odata_d.spin_amount     = spin_i;
      odata_d.boost_left_out  = flags_i.spin_sel && flags_i.boost_left;
      odata_d.boost_right_out = flags_i.spin_sel && flags_i.boost_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= trdf_pkg::MODE_STOP;
      speed_q <= '0;
      hold_q  <= '0;
    end else if (pop) begin
      mode_q  <= mode_d;
      speed_q <= speed_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (pop) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      odata_q <= odata_d;
    end
  end

endmodule

// ----- hw/rtl/throttle_ramp_drive_fsm_top.sv -----
// Drive-command state machine: one input item per tick (pedals, nitro buttons, stick, elapsed
// time) yields exactly one command item. The block takes one item every clock cycle while
// the output side does not stall; each item passes through the front-end register, the queue
// and the output register. The front end registers the rate-times-time and stick-square
// products and classifies the stick, a small queue (QUEUE_DEPTH items) decouples it from the
// back end, and the back end runs the five-mode drive machine with its speed ramp, clamp and
// hold timer, one item per cycle unless the output stalls, into an output register. Both
// sides stall independently through tready. Ramp steps are rate * time_step >> TIME_FRAC_BITS.
// Write configuration over the register port only while no item is in flight.
module throttle_ramp_drive_fsm_top #(
  parameter int unsigned TIME_FRAC_BITS = 16,
  parameter int unsigned QUEUE_DEPTH    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] pedal_accel, [1] pedal_brake, [2] boost_left, [3] boost_right,
  // [19:4] stick_lateral, [35:20] stick_other, [51:36] time_step, [55:52] zero
  input  logic [55:0] s_axis_tdata,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] send_valid, [24:1] drive_speed, [41:25] spin_amount, [42] boost_left_out,
  // [43] boost_right_out, [46:44] mode_now, [47] zero
  output logic [47:0] m_axis_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned STEP_W = 32 - TIME_FRAC_BITS;
  localparam int unsigned ENT_W  = $bits(trdf_pkg::flags_t) + 3 * STEP_W
                                   + trdf_pkg::SPIN_W + trdf_pkg::DT_W;

  logic [trdf_pkg::RATE_W-1:0]  accel_rate_q, brake_rate_q, coast_rate_q, spin_rate_q;
  logic [trdf_pkg::MAXS_W-1:0]  max_speed_q;
  logic [trdf_pkg::HTIME_W-1:0] hold_fwd_time_q, hold_rev_time_q;
  logic [31:0]                  dead_zone_sq_q;

  trdf_pkg::reg_e reg_idx;
  logic           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = trdf_pkg::reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_rate_q    <= 16'd1000;
      brake_rate_q    <= 16'd3000;
      coast_rate_q    <= 16'd500;
      max_speed_q     <= 23'd100000;
      hold_fwd_time_q <= 24'd32768;
      hold_rev_time_q <= 24'd32768;
      spin_rate_q     <= 16'd1000;
      dead_zone_sq_q  <= 32'd1000000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        trdf_pkg::REG_ACCEL_RATE:    accel_rate_q    <= pwdata[15:0];
        trdf_pkg::REG_BRAKE_RATE:    brake_rate_q    <= pwdata[15:0];
        trdf_pkg::REG_COAST_RATE:    coast_rate_q    <= pwdata[15:0];
        trdf_pkg::REG_MAX_SPEED:     max_speed_q     <= pwdata[22:0];
        trdf_pkg::REG_HOLD_FWD_TIME: hold_fwd_time_q <= pwdata[23:0];
        trdf_pkg::REG_HOLD_REV_TIME: hold_rev_time_q <= pwdata[23:0];
        trdf_pkg::REG_SPIN_RATE:     spin_rate_q     <= pwdata[15:0];
        trdf_pkg::REG_DEAD_ZONE_SQ:  dead_zone_sq_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      trdf_pkg::REG_ACCEL_RATE:    prdata = 32'(accel_rate_q);
      trdf_pkg::REG_BRAKE_RATE:    prdata = 32'(brake_rate_q);
      trdf_pkg::REG_COAST_RATE:    prdata = 32'(coast_rate_q);
      trdf_pkg::REG_MAX_SPEED:     prdata = 32'(max_speed_q);
      trdf_pkg::REG_HOLD_FWD_TIME: prdata = 32'(hold_fwd_time_q);
      trdf_pkg::REG_HOLD_REV_TIME: prdata = 32'(hold_rev_time_q);
      trdf_pkg::REG_SPIN_RATE:     prdata = 32'(spin_rate_q);
      trdf_pkg::REG_DEAD_ZONE_SQ:  prdata = dead_zone_sq_q;
      default:                     prdata = '0;
    endcase
  end

  // Front end
  logic                        f_valid, f_ready;
  trdf_pkg::flags_t            f_flags, b_flags;
  logic [STEP_W-1:0]           f_sa, f_sb, f_sc, b_sa, b_sb, b_sc;
  logic [trdf_pkg::SPIN_W-1:0] f_spin, b_spin;
  logic [trdf_pkg::DT_W-1:0]   f_dt, b_dt;

  trdf_front #(
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .pedal_accel_i   (s_axis_tdata[0]),
    .pedal_brake_i   (s_axis_tdata[1]),
    .boost_left_i    (s_axis_tdata[2]),
    .boost_right_i   (s_axis_tdata[3]),
    .stick_lateral_i ($signed(s_axis_tdata[19:4])),
    .stick_other_i   ($signed(s_axis_tdata[35:20])),
    .time_step_i     (s_axis_tdata[51:36]),
    .accel_rate_i    (accel_rate_q),
    .brake_rate_i    (brake_rate_q),
    .coast_rate_i    (coast_rate_q),
    .spin_rate_i     (spin_rate_q),
    .dead_zone_sq_i  (dead_zone_sq_q),
    .out_valid_o     (f_valid),
    .out_ready_i     (f_ready),
    .flags_o         (f_flags),
    .step_a_o        (f_sa),
    .step_b_o        (f_sb),
    .step_c_o        (f_sc),
    .spin_o          (f_spin),
    .dt_o            (f_dt)
  );

  // Queue between front and back
  logic             q_valid, q_ready;
  logic [ENT_W-1:0] q_wdata, q_rdata;

  assign q_wdata = {f_flags, f_sa, f_sb, f_sc, f_spin, f_dt};
  assign {b_flags, b_sa, b_sb, b_sc, b_spin, b_dt} = q_rdata;

  trdf_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_wdata),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_rdata)
  );

  // Back end
  trdf_pkg::out_t b_out;

  trdf_back #(
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (q_valid),
    .in_ready_o      (q_ready),
    .flags_i         (b_flags),
    .step_a_i        (b_sa),
    .step_b_i        (b_sb),
    .step_c_i        (b_sc),
    .spin_i          (b_spin),
    .dt_i            (b_dt),
    .max_speed_i     (max_speed_q),
    .hold_fwd_time_i (hold_fwd_time_q),
    .hold_rev_time_i (hold_rev_time_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (b_out)
  );

  assign m_axis_tdata = b_out;

endmodule
